[design/rt_correlation_distance_unit_macros.svh]
// ----------------------------------------------------------------------------
// rt correlation distance unit - assertion macros
// shared concurrent check forms, clocked on aclk, off while aresetn is low
// ----------------------------------------------------------------------------
`ifndef RT_CORRELATION_DISTANCE_UNIT_MACROS_SVH
`define RT_CORRELATION_DISTANCE_UNIT_MACROS_SVH

// condition that holds at every clock edge
`define RCD_ASSERT(name, cond) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("rcd check failed");

// condition in one cycle implies a consequence in the next
`define RCD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rcd check failed");

`endif

[design/rcd_pkg.sv]
// ----------------------------------------------------------------------------
// rcd_pkg
// widths, constants and register indices of the rt correlation distance unit
// ----------------------------------------------------------------------------
package rcd_pkg;

    // intensity pairs taken per vector before further pairs are dropped
    localparam int MAX_INTENSITIES = 256;

    localparam int VAL_W  = 24;
    localparam int CNT_W  = $clog2(MAX_INTENSITIES + 2);
    localparam int SUM_W  = 32;
    localparam int SQ_W   = 56;
    localparam int VAR_W  = CNT_W + SQ_W;
    localparam int DIST_W = 17;
    localparam int CFG_W  = 24;
    localparam int EXP_W  = 21;

    localparam logic [DIST_W-1:0] ONE_Q16 = DIST_W'(65536);
    localparam logic [EXP_W-1:0]  EXP_CAP = EXP_W'(16 * 65536);

    // configuration register indices
    typedef enum logic [1:0] {
        REG_CORR_SIGMA     = 2'd0,
        REG_TIME_SIGMA     = 2'd1,
        REG_TIME_LIMIT     = 2'd2,
        REG_DISTANCE_LIMIT = 2'd3
    } cfg_index_t;

endpackage

[design/rt_correlation_distance_unit.sv]
// ----------------------------------------------------------------------------
// rt_correlation_distance_unit
// gaussian rt / correlation distance between two vectors streamed as pairs
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  s_       in         tdata: value_a, value_b; tlast: last
//  m_       out        tdata: distance; tuser: gated, degenerate
//  cfg_     in         write enable, register index, data
//
//  an intensity pair is accepted, then three products go through the
//  shared 32x32 multiplier, each added to its sum; the rt pair is only stored
//  the last pair then runs a sequencer over a serial shift-add multiplier,
//  a bit-serial square root and a restoring divider; the 14 divides
//  of the exp series dominate the run time
//  s_tready is low while a pair's products run and from the last pair until the result beat is taken
//  reset is synchronous, clears sums, counters and configuration at once, no clearing pass
// ----------------------------------------------------------------------------
module rt_correlation_distance_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [47:0]                s_tdata,   // value_a[23:0], value_b[47:24]
    input  logic                       s_tlast,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [23:0]                m_tdata,   // distance[16:0], zero fill
    output logic [1:0]                 m_tuser,   // gated[0], degenerate[1]
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_addr,
    input  logic [rcd_pkg::CFG_W-1:0]  cfg_wdata
);
    import rcd_pkg::*;

    `include "rt_correlation_distance_unit_macros.svh"

    typedef enum logic [5:0] {
        S_IDLE, S_EA, S_EB, S_EC, S_ED,
        S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_F7, S_F8, S_F9,
        S_F10, S_F10B, S_F11, S_F12, S_F13, S_F14, S_F15, S_F16, S_F17,
        S_X1, S_X2, S_X3, S_Q1, S_Q2, S_Z,
        S_MUL, S_DIV, S_SQRT, S_PWAIT, S_OUT
    } state_t;

    localparam int HMAX = (VAR_W - 62 + 1) / 2;
    localparam int H_W  = $clog2(HMAX + 1);

    state_t state_reg, ret_reg;

    // configuration
    logic [CFG_W-1:0]  corr_sigma_reg, time_sigma_reg, time_limit_reg;
    logic [DIST_W-1:0] distance_limit_reg;

    // vector state
    logic [CNT_W-1:0] cnt_reg;
    logic [VAL_W-1:0] time_a_reg, time_b_reg, ea_reg, eb_reg;
    logic [SUM_W-1:0] sum_a_reg, sum_b_reg;
    logic [SQ_W-1:0]  sq_a_reg, sq_b_reg, sp_reg;
    logic             last_reg;

    // shared units
    logic [31:0]  fa_reg, fb_reg;
    logic [63:0]  prod_reg;
    logic [127:0] ma_reg, acc_reg;
    logic [63:0]  mb_reg;
    logic [63:0]  drem_reg, dnum_reg, dden_reg, dquo_reg;
    logic [6:0]   it_reg;

    // final phase values
    logic [VAR_W-1:0]  p_reg, va_reg, vb_reg, cmag_reg;
    logic [62:0]       d_reg;
    logic              neg_reg;
    logic [DIST_W-1:0] cq_reg;
    logic [47:0]       tt_reg;
    logic [EXP_W-1:0]  x_reg;
    logic [31:0]       g_reg, term_reg, sum_reg;
    logic [3:0]        k_reg;
    logic [1:0]        qi_reg;

    // result
    logic [DIST_W-1:0] dist_reg;
    logic              gated_reg, degen_reg, m_valid_reg;

    // combinational helpers
    logic [127:0]      acc_add;
    logic [65:0]       sq_r, sq_t, sq_d;
    logic              sq_ge;
    logic [64:0]       dv_r, dv_d;
    logic              dv_ge;
    logic [CNT_W-1:0]  n_cnt;
    logic [VAL_W-1:0]  t_abs, st_eff, sr_eff;
    logic [H_W-1:0]    ha, hb;
    logic [2:0]        sh;
    logic [VAR_W-1:0]  diff;
    logic [17:0]       rq;
    logic [EXP_W-1:0]  q_cap;
    logic [EXP_W:0]    e_sum;
    logic [EXP_W-1:0]  e_cap;
    logic [16:0]       p_exp;
    logic [DIST_W-1:0] d_exp;
    logic [127:0]      p_wide;
    logic              p_lt;

    // smallest half shift h with v >> 2h below 2^62
    function automatic logic [H_W-1:0] even_half(input logic [VAR_W-1:0] v);
        logic [H_W-1:0] h;
        h = H_W'(HMAX);
        for (int i = HMAX; i >= 0; i--) begin
            if ((v >> (2 * i)) < (VAR_W'(1) << 62)) begin
                h = H_W'(i);
            end
        end
        return h;
    endfunction

    // arithmetic shared by the sequencer
    always_comb begin
        acc_add = acc_reg + ma_reg;
        sq_r    = {ma_reg[63:0], acc_reg[127:126]};
        sq_t    = {mb_reg, 2'b01};
        sq_ge   = sq_r >= sq_t;
        sq_d    = sq_r - sq_t;
        dv_r    = {drem_reg, dnum_reg[63]};
        dv_ge   = dv_r >= {1'b0, dden_reg};
        dv_d    = dv_r - {1'b0, dden_reg};
        n_cnt   = (cnt_reg != '0) ? cnt_reg - CNT_W'(1) : '0;
        t_abs   = (time_a_reg >= time_b_reg) ? time_a_reg - time_b_reg
                                             : time_b_reg - time_a_reg;
        st_eff  = (time_sigma_reg != '0) ? time_sigma_reg : VAL_W'(1);
        sr_eff  = (corr_sigma_reg != '0) ? corr_sigma_reg : VAL_W'(1);
        ha      = even_half(va_reg);
        hb      = even_half(vb_reg);
        sh      = 3'(ha) + 3'(hb);
        p_wide  = 128'(p_reg);
        p_lt    = p_wide < acc_reg;
        diff    = p_lt ? VAR_W'(acc_reg - p_wide) : VAR_W'(p_wide - acc_reg);
        rq      = neg_reg ? 18'(ONE_Q16) + 18'(cq_reg) : 18'(ONE_Q16) - 18'(cq_reg);
        q_cap   = (dquo_reg > 64'(EXP_CAP)) ? EXP_CAP : dquo_reg[EXP_W-1:0];
        e_sum   = (EXP_W+1)'(x_reg) + (EXP_W+1)'(q_cap);
        e_cap   = (e_sum > (EXP_W+1)'(EXP_CAP)) ? EXP_CAP : e_sum[EXP_W-1:0];
        p_exp   = 17'((33'(sum_reg) + 33'(1 << 14)) >> 15);
        d_exp   = ONE_Q16 - p_exp;
    end

    // sequencer, datapath registers and result beat
    always_ff @(posedge aclk) begin
        prod_reg <= 64'(fa_reg) * 64'(fb_reg);
        if (!aresetn) begin
            state_reg          <= S_IDLE;
            ret_reg            <= S_IDLE;
            corr_sigma_reg     <= CFG_W'(32768);
            time_sigma_reg     <= CFG_W'(256);
            time_limit_reg     <= CFG_W'(16777215);
            distance_limit_reg <= ONE_Q16;
            cnt_reg            <= '0;
            time_a_reg         <= '0;
            time_b_reg         <= '0;
            sum_a_reg          <= '0;
            sum_b_reg          <= '0;
            sq_a_reg           <= '0;
            sq_b_reg           <= '0;
            sp_reg             <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_we) begin
                unique case (cfg_index_t'(cfg_addr))
                    REG_CORR_SIGMA:     corr_sigma_reg     <= cfg_wdata;
                    REG_TIME_SIGMA:     time_sigma_reg     <= cfg_wdata;
                    REG_TIME_LIMIT:     time_limit_reg     <= cfg_wdata;
                    REG_DISTANCE_LIMIT: distance_limit_reg <= cfg_wdata[DIST_W-1:0];
                endcase
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        last_reg <= s_tlast;
                        if (cnt_reg == '0) begin
                            time_a_reg <= s_tdata[23:0];
                            time_b_reg <= s_tdata[47:24];
                            cnt_reg    <= CNT_W'(1);
                            if (s_tlast) state_reg <= S_F0;
                        end else if (cnt_reg <= CNT_W'(MAX_INTENSITIES)) begin
                            ea_reg    <= s_tdata[23:0];
                            eb_reg    <= s_tdata[47:24];
                            sum_a_reg <= sum_a_reg + SUM_W'(s_tdata[23:0]);
                            sum_b_reg <= sum_b_reg + SUM_W'(s_tdata[47:24]);
                            cnt_reg   <= cnt_reg + CNT_W'(1);
                            fa_reg    <= 32'(s_tdata[23:0]);
                            fb_reg    <= 32'(s_tdata[23:0]);
                            state_reg <= S_EA;
                        end else if (s_tlast) begin
                            state_reg <= S_F0;
                        end
                    end
                end

                // products of one intensity pair
                S_EA: begin
                    fa_reg    <= 32'(eb_reg);
                    fb_reg    <= 32'(eb_reg);
                    state_reg <= S_EB;
                end
                S_EB: begin
                    sq_a_reg  <= sq_a_reg + SQ_W'(prod_reg);
                    fa_reg    <= 32'(ea_reg);
                    fb_reg    <= 32'(eb_reg);
                    state_reg <= S_EC;
                end
                S_EC: begin
                    sq_b_reg  <= sq_b_reg + SQ_W'(prod_reg);
                    state_reg <= S_ED;
                end
                S_ED: begin
                    sp_reg    <= sp_reg + SQ_W'(prod_reg);
                    state_reg <= last_reg ? S_F0 : S_IDLE;
                end

                // variances
                S_F0: begin
                    ma_reg <= 128'(sq_a_reg); mb_reg <= 64'(n_cnt); acc_reg <= '0;
                    ret_reg <= S_F1; state_reg <= S_MUL;
                end
                S_F1: begin
                    p_reg  <= VAR_W'(acc_reg);
                    ma_reg <= 128'(sum_a_reg); mb_reg <= 64'(sum_a_reg); acc_reg <= '0;
                    ret_reg <= S_F2; state_reg <= S_MUL;
                end
                S_F2: begin
                    va_reg <= p_lt ? '0 : VAR_W'(p_wide - acc_reg);
                    ma_reg <= 128'(sq_b_reg); mb_reg <= 64'(n_cnt); acc_reg <= '0;
                    ret_reg <= S_F3; state_reg <= S_MUL;
                end
                S_F3: begin
                    p_reg  <= VAR_W'(acc_reg);
                    ma_reg <= 128'(sum_b_reg); mb_reg <= 64'(sum_b_reg); acc_reg <= '0;
                    ret_reg <= S_F4; state_reg <= S_MUL;
                end
                S_F4: begin
                    vb_reg    <= p_lt ? '0 : VAR_W'(p_wide - acc_reg);
                    state_reg <= S_F5;
                end

                // gates ahead of the correlation
                S_F5: begin
                    degen_reg <= (va_reg == '0) || (vb_reg == '0);
                    dist_reg  <= ONE_Q16;
                    gated_reg <= 1'b0;
                    if (t_abs > time_limit_reg) begin
                        gated_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end else if ((va_reg == '0) || (vb_reg == '0)) begin
                        state_reg <= S_OUT;
                    end else begin
                        ma_reg  <= 128'(62'(va_reg >> (2 * ha)));
                        mb_reg  <= 64'(62'(vb_reg >> (2 * hb)));
                        acc_reg <= '0;
                        ret_reg <= S_F6; state_reg <= S_MUL;
                    end
                end
                S_F6: begin
                    ma_reg <= '0; mb_reg <= '0; it_reg <= 7'd64;
                    ret_reg <= S_F7; state_reg <= S_SQRT;
                end
                S_F7: begin
                    d_reg  <= mb_reg[62:0];
                    ma_reg <= 128'(sp_reg); mb_reg <= 64'(n_cnt); acc_reg <= '0;
                    ret_reg <= S_F8; state_reg <= S_MUL;
                end
                S_F8: begin
                    p_reg  <= VAR_W'(acc_reg);
                    ma_reg <= 128'(sum_a_reg); mb_reg <= 64'(sum_b_reg); acc_reg <= '0;
                    ret_reg <= S_F9; state_reg <= S_MUL;
                end
                S_F9: begin
                    neg_reg   <= p_lt;
                    cmag_reg  <= diff >> sh;
                    state_reg <= S_F10;
                end

                // correlation magnitude in q1.16
                S_F10: begin
                    if (cmag_reg >= VAR_W'(d_reg)) begin
                        cq_reg    <= ONE_Q16;
                        state_reg <= S_F11;
                    end else begin
                        drem_reg <= 64'(cmag_reg); dnum_reg <= '0;
                        dden_reg <= 64'(d_reg);    dquo_reg <= '0;
                        it_reg   <= 7'd16;
                        ret_reg  <= S_F10B; state_reg <= S_DIV;
                    end
                end
                S_F10B: begin
                    cq_reg    <= DIST_W'(dquo_reg[15:0]);
                    state_reg <= S_F11;
                end

                // exponent terms t^2/st^2 and (1-r)^2/sr^2
                S_F11: begin
                    fa_reg <= 32'(t_abs); fb_reg <= 32'(t_abs);
                    ret_reg <= S_F12; state_reg <= S_PWAIT;
                end
                S_F12: begin
                    tt_reg <= prod_reg[47:0];
                    fa_reg <= 32'(st_eff); fb_reg <= 32'(st_eff);
                    ret_reg <= S_F13; state_reg <= S_PWAIT;
                end
                S_F13: begin
                    drem_reg <= '0; dnum_reg <= 64'(tt_reg) << 15;
                    dden_reg <= prod_reg; dquo_reg <= '0; it_reg <= 7'd64;
                    ret_reg  <= S_F14; state_reg <= S_DIV;
                end
                S_F14: begin
                    x_reg  <= q_cap;
                    fa_reg <= 32'(rq); fb_reg <= 32'(rq);
                    ret_reg <= S_F15; state_reg <= S_PWAIT;
                end
                S_F15: begin
                    tt_reg <= prod_reg[47:0];
                    fa_reg <= 32'(sr_eff); fb_reg <= 32'(sr_eff);
                    ret_reg <= S_F16; state_reg <= S_PWAIT;
                end
                S_F16: begin
                    drem_reg <= '0; dnum_reg <= 64'(tt_reg) << 15;
                    dden_reg <= prod_reg; dquo_reg <= '0; it_reg <= 7'd64;
                    ret_reg  <= S_F17; state_reg <= S_DIV;
                end
                S_F17: begin
                    g_reg     <= {e_cap, 11'b0};
                    sum_reg   <= 32'h8000_0000;
                    term_reg  <= 32'h8000_0000;
                    k_reg     <= 4'd1;
                    state_reg <= S_X1;
                end

                // exp series, one term per pass
                S_X1: begin
                    fa_reg <= term_reg; fb_reg <= g_reg;
                    ret_reg <= S_X2; state_reg <= S_PWAIT;
                end
                S_X2: begin
                    drem_reg <= '0; dnum_reg <= 64'(prod_reg[63:31]);
                    dden_reg <= 64'(k_reg); dquo_reg <= '0; it_reg <= 7'd64;
                    ret_reg  <= S_X3; state_reg <= S_DIV;
                end
                S_X3: begin
                    term_reg <= dquo_reg[31:0];
                    sum_reg  <= k_reg[0] ? sum_reg - dquo_reg[31:0]
                                         : sum_reg + dquo_reg[31:0];
                    if (k_reg == 4'd14) begin
                        qi_reg    <= '0;
                        state_reg <= S_Q1;
                    end else begin
                        k_reg     <= k_reg + 4'd1;
                        state_reg <= S_X1;
                    end
                end

                // four squarings with round half up
                S_Q1: begin
                    fa_reg <= sum_reg; fb_reg <= sum_reg;
                    ret_reg <= S_Q2; state_reg <= S_PWAIT;
                end
                S_Q2: begin
                    sum_reg   <= 32'((prod_reg + 64'(1 << 30)) >> 31);
                    qi_reg    <= qi_reg + 2'd1;
                    state_reg <= (qi_reg == 2'd3) ? S_Z : S_Q1;
                end
                S_Z: begin
                    if (d_exp > distance_limit_reg) begin
                        dist_reg  <= ONE_Q16;
                        gated_reg <= 1'b1;
                    end else begin
                        dist_reg  <= d_exp;
                    end
                    state_reg <= S_OUT;
                end

                // serial shift-add multiply, ends when the multiplier runs out
                S_MUL: begin
                    if (mb_reg == '0) begin
                        state_reg <= ret_reg;
                    end else begin
                        if (mb_reg[0]) acc_reg <= acc_add;
                        ma_reg <= ma_reg << 1;
                        mb_reg <= mb_reg >> 1;
                    end
                end

                // restoring divide, one quotient bit a cycle
                S_DIV: begin
                    drem_reg <= dv_ge ? dv_d[63:0] : dv_r[63:0];
                    dnum_reg <= dnum_reg << 1;
                    dquo_reg <= {dquo_reg[62:0], dv_ge};
                    it_reg   <= it_reg - 7'd1;
                    if (it_reg == 7'd1) state_reg <= ret_reg;
                end

                // digit-by-digit square root, two radicand bits a cycle
                S_SQRT: begin
                    ma_reg  <= 128'(sq_ge ? sq_d : sq_r);
                    mb_reg  <= {mb_reg[62:0], sq_ge};
                    acc_reg <= acc_reg << 2;
                    it_reg  <= it_reg - 7'd1;
                    if (it_reg == 7'd1) state_reg <= ret_reg;
                end

                // wait for the product to reach the multiplier register
                S_PWAIT: begin
                    state_reg <= ret_reg;
                end

                // result beat, vector cleared once taken
                S_OUT: begin
                    m_valid_reg <= 1'b1;
                    if (m_valid_reg && m_tready) begin
                        m_valid_reg <= 1'b0;
                        cnt_reg     <= '0;
                        time_a_reg  <= '0;
                        time_b_reg  <= '0;
                        sum_a_reg   <= '0;
                        sum_b_reg   <= '0;
                        sq_a_reg    <= '0;
                        sq_b_reg    <= '0;
                        sp_reg      <= '0;
                        state_reg   <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, dist_reg};
    assign m_tuser  = {degen_reg, gated_reg};

    // checks
    `RCD_ASSERT(a_no_overlap, !(s_tready && m_tvalid))
    `RCD_ASSERT(a_dist_range, !m_tvalid || (dist_reg <= ONE_Q16))
    `RCD_ASSERT(a_gate_full, !m_tvalid || !gated_reg || (dist_reg == ONE_Q16))
    `RCD_ASSERT_NEXT(a_clear_after_beat, m_tvalid && m_tready, cnt_reg == '0)

endmodule
